/* rtl/core/vrd_pkg.sv */
// Package for the voxel reservoir downsampler.
// Holds the table sizes, field widths, generator constants and the sequencer state type.
// No dependencies.
package vrd_pkg;

  localparam int MAX_VOXELS = 1024;
  localparam int SLOT_W     = $clog2(MAX_VOXELS);
  localparam int USED_W     = SLOT_W + 1;
  localparam int MAX_POINTS = 65536;
  localparam int PC_W       = $clog2(MAX_POINTS) + 1;
  localparam int CELL_BITS  = 21;
  localparam int KEY_W      = 3 * CELL_BITS;
  localparam int COORD_W    = 32;
  localparam int INV_W      = 24;
  localparam int PROD_W     = COORD_W + INV_W;
  localparam int CNT_W      = 16;
  localparam int RNG_W      = 31;
  localparam int RMUL_W     = 15;
  localparam int RPROD_W    = RNG_W + RMUL_W;

  localparam logic [RMUL_W-1:0] RNG_MUL   = RMUL_W'(16807);
  localparam logic [RNG_W-1:0]  RNG_MOD   = 31'h7FFF_FFFF;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 16'hFFFF;
  localparam logic [INV_W-1:0]  INV_RESET = 24'h01_0000;

  // Register index of the only configuration register.
  localparam logic REG_INV_RES = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RND,
    ST_SEARCH,
    ST_RNGM,
    ST_UPD,
    ST_DIV,
    ST_FIN
  } vrd_state_t;

endpackage

/* rtl/core/vrd_mod_unit.sv */
// Iterative remainder unit: one restoring step per cycle.
// Computes dividend mod divisor for the reservoir draw; uses vrd_pkg.
module vrd_mod_unit import vrd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RNG_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [CNT_W-1:0] remainder
);

  localparam int STEP_W = $clog2(RNG_W + 1);

  logic [RNG_W-1:0]  dq;
  logic [CNT_W-1:0]  dv;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  assign trial = {rem, dq[RNG_W-1]};
  assign fits  = trial >= {1'b0, dv};

  // Step sequencing and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(RNG_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and dividend shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (busy) begin
      dq  <= {dq[RNG_W-2:0], 1'b0};
      rem <= fits ? CNT_W'(trial - {1'b0, dv}) : trial[CNT_W-1:0];
    end
  end

  assign remainder = rem;

`ifndef SYNTHESIS
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < dv))
    else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a running division");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("division did not start");
`endif

endmodule

/* rtl/core/voxel_reservoir_downsampler_unit.sv */
// Top level of the voxel reservoir downsampler.
// Holds the sequencer, cell rounding, slot table memories and generator; uses vrd_pkg
// and vrd_mod_unit.
//
// Usage: one 3D point enters per input transaction (in_valid/in_ready) and yields
// exactly one result transaction (out_valid/out_ready). Each coordinate is scaled by
// inv_resolution (APB register at address 0) with one shared multiplier, rounded
// to a 21-bit cell, and the packed key is searched linearly in the slot table, one
// slot read per cycle. A repeat voxel then advances the generator and draws the
// reservoir decision with a bit-serial remainder unit. A point that arrives after the
// point counter ran out skips the rounding and the slot search, goes straight to the
// final step and is reported as overflow with point index and slot zero; the table
// and the generator stay untouched, and the point counter holds its value.
// One point is handled at a time; in_ready is high only while the sequencer idles.
// The result sits in an output register, so the next point is taken while it waits;
// if out_ready is held low, the following point stalls in its final step until the
// register frees. Reset empties the table, clears the point counter, sets the
// generator to one and inv_resolution to 65536. first_point does the same for the
// table, counter and generator before its own point is handled.
module voxel_reservoir_downsampler_unit import vrd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // Point channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic signed [COORD_W-1:0] z_coord,
  input  logic                      first_point,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               point_index,
  output logic [SLOT_W-1:0]         voxel_slot,
  output logic                      new_voxel,
  output logic                      take_point,
  output logic                      overflow,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  vrd_state_t state, state_next;

  logic [INV_W-1:0]   inv_res;
  logic [COORD_W-1:0] crd [3];
  logic [1:0]         cidx;
  logic [PROD_W-1:0]  cprod;
  logic [KEY_W-1:0]   key;
  logic [USED_W-1:0]  used;
  logic [PC_W-1:0]    pc;
  logic [RNG_W-1:0]   rng;
  logic [USED_W-1:0]  idx;
  logic               pv;
  logic [SLOT_W-1:0]  pidx;
  logic [SLOT_W-1:0]  slot;
  logic [RPROD_W-1:0] rprod;
  logic [CNT_W-1:0]   cnt_reg;

  logic [KEY_W-1:0]   key_mem [MAX_VOXELS];
  logic [CNT_W-1:0]   cnt_mem [MAX_VOXELS];
  logic [KEY_W-1:0]   key_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [15:0]        r_idx;
  logic [SLOT_W-1:0]  r_slot;
  logic               r_new;
  logic               r_take;
  logic               r_ovf;

  logic               accept;
  logic               cfg_wr;
  logic [PC_W-1:0]    pc_eff;
  logic               sel_neg;
  logic [COORD_W-1:0] sel_mag;
  logic [PROD_W:0]    rnd_sum;
  logic [CELL_BITS-1:0] cell_mag;
  logic [CELL_BITS-1:0] cell_val;
  logic               match;
  logic               search_end;
  logic               table_full;
  logic [RNG_W:0]     fold;
  logic [RNG_W-1:0]   rng_new;
  logic [CNT_W-1:0]   cnt_new;
  logic               div_start;
  logic               div_done;
  logic [CNT_W-1:0]   div_rem;
  logic               out_free;

  assign accept = in_valid && in_ready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign pc_eff = first_point ? '0 : pc;

  // Configuration register and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_res <= INV_RESET;
    end else if (cfg_wr && paddr[2] == REG_INV_RES) begin
      inv_res <= pwdata[INV_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_INV_RES) begin
      prdata = {{(32 - INV_W){1'b0}}, inv_res};
    end
  end

  // Cell rounding: magnitude times scale, round half away from zero, wrap.
  assign sel_neg  = crd[cidx][COORD_W-1];
  assign sel_mag  = sel_neg ? (~crd[cidx] + 1'b1) : crd[cidx];
  assign rnd_sum  = {1'b0, cprod} + (PROD_W + 1)'(33'h0_8000_0000);
  assign cell_mag = rnd_sum[32 +: CELL_BITS];
  assign cell_val = sel_neg ? (~cell_mag + 1'b1) : cell_mag;

  // Search and generator arithmetic.
  assign match      = pv && (key_q == key);
  assign search_end = !pv && (idx >= used);
  assign table_full = used >= USED_W'(MAX_VOXELS);
  assign fold       = {1'b0, rprod[RNG_W-1:0]} + (RNG_W + 1)'(rprod[RPROD_W-1:RNG_W]);
  assign rng_new    = (fold >= {1'b0, RNG_MOD}) ? RNG_W'(fold - {1'b0, RNG_MOD})
                                                : fold[RNG_W-1:0];
  assign cnt_new    = (cnt_q < COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign out_free   = !out_valid || out_ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (pc_eff >= PC_W'(MAX_POINTS)) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_RND;
      end
      ST_RND: begin
        state_next = (cidx == 2'd2) ? ST_SEARCH : ST_MUL;
      end
      ST_SEARCH: begin
        if (match) begin
          state_next = ST_RNGM;
        end else if (search_end) begin
          state_next = ST_FIN;
        end
      end
      ST_RNGM: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state: counters, table fill, generator.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      pc   <= '0;
      rng  <= RNG_W'(1);
      pv   <= 1'b0;
    end else begin
      pv <= 1'b0;
      if (accept) begin
        if (first_point) begin
          used <= '0;
          rng  <= RNG_W'(1);
        end
        if (pc_eff < PC_W'(MAX_POINTS)) begin
          pc <= pc_eff + 1'b1;
        end else begin
          pc <= pc_eff;
        end
      end
      if (state == ST_SEARCH) begin
        pv <= !match && (idx < used);
        if (search_end && !match && !table_full) begin
          used <= used + 1'b1;
        end
      end
      if (state == ST_UPD) begin
        rng <= rng_new;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      crd[0] <= x_coord;
      crd[1] <= y_coord;
      crd[2] <= z_coord;
      cidx   <= '0;
      idx    <= '0;
      r_idx  <= pc_eff[15:0];
      r_slot <= '0;
      r_new  <= 1'b0;
      r_take <= 1'b0;
      r_ovf  <= pc_eff >= PC_W'(MAX_POINTS);
      if (pc_eff >= PC_W'(MAX_POINTS)) begin
        r_idx <= '0;
      end
    end
    if (state == ST_MUL) begin
      cprod <= PROD_W'(sel_mag) * PROD_W'(inv_res);
    end
    if (state == ST_RND) begin
      key  <= {key[KEY_W-CELL_BITS-1:0], cell_val};
      cidx <= cidx + 1'b1;
    end
    if (state == ST_SEARCH) begin
      if (idx < used) begin
        idx <= idx + 1'b1;
      end
      pidx <= idx[SLOT_W-1:0];
      if (match) begin
        slot <= pidx;
      end else if (search_end) begin
        if (table_full) begin
          r_ovf <= 1'b1;
        end else begin
          r_slot <= used[SLOT_W-1:0];
          r_new  <= 1'b1;
          r_take <= 1'b1;
        end
      end
    end
    if (state == ST_RNGM) begin
      rprod  <= RPROD_W'(rng) * RPROD_W'(RNG_MUL);
      r_slot <= slot;
    end
    if (state == ST_UPD) begin
      cnt_reg <= cnt_new;
    end
    if (state == ST_DIV && div_done) begin
      r_take <= div_rem == cnt_reg - 1'b1;
    end
  end

  // Slot key memory: written on a new voxel, read one slot per cycle while searching.
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && search_end && !match && !table_full) begin
      key_mem[used[SLOT_W-1:0]] <= key;
    end
    key_q <= key_mem[idx[SLOT_W-1:0]];
  end

  // Slot count memory: one on a new voxel, saturating increment on a repeat.
  always_ff @(posedge clk) begin
    if (state == ST_SEARCH && search_end && !match && !table_full) begin
      cnt_mem[used[SLOT_W-1:0]] <= CNT_W'(1);
    end else if (state == ST_UPD) begin
      cnt_mem[slot] <= cnt_new;
    end
    cnt_q <= cnt_mem[slot];
  end

  // Reservoir draw: new generator value modulo the voxel count.
  vrd_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rng_new),
    .divisor   (cnt_new),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      point_index <= r_idx;
      voxel_slot  <= r_slot;
      new_voxel   <= r_new;
      take_point  <= r_take;
      overflow    <= r_ovf;
    end
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(MAX_VOXELS))
    else $error("slot fill count beyond table size");
  a_new_takes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_voxel) |-> (take_point && !overflow))
    else $error("new voxel result without take");
  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (voxel_slot == '0 && !new_voxel && !take_point))
    else $error("dropped point carries slot data");
  a_rng_nonzero: assert property (@(posedge clk) disable iff (rst)
    rng != '0)
    else $error("generator state reached zero");
`endif

endmodule
